### design/multi_series_frame_sequencer_defines.svh
// assertion macros for the multi series frame sequencer
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef MULTI_SERIES_FRAME_SEQUENCER_DEFINES_SVH
`define MULTI_SERIES_FRAME_SEQUENCER_DEFINES_SVH

// consequent checked in the same cycle
`define MSFS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("msfs same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define MSFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("msfs next-cycle check failed");

`endif

### design/msfs_pkg.sv
// shared types, constants and codes for the multi series frame sequencer
// no dependencies; table depths are powers of two
`default_nettype none

package msfs_pkg;

    localparam int BANK_COUNT   = 16;
    localparam int SERIES_LIMIT = 8;
    localparam int SERIES_DEPTH = 64;
    localparam int FRAME_DEPTH  = 256;

    localparam int BANK_AW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int SER_AW  = (SERIES_DEPTH > 1) ? $clog2(SERIES_DEPTH) : 1;
    localparam int FRM_AW  = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int SLOT_W  = (SERIES_LIMIT > 1) ? $clog2(SERIES_LIMIT) : 1;
    localparam int IDX_W   = $clog2(SERIES_LIMIT + 1);
    localparam int BCNT_W  = $clog2(SERIES_LIMIT + 2);

    // input modes
    localparam logic [2:0] MODE_FRAME  = 3'd0;
    localparam logic [2:0] MODE_SERIES = 3'd1;
    localparam logic [2:0] MODE_BANK   = 3'd2;
    localparam logic [2:0] MODE_BEGIN  = 3'd3;
    localparam logic [2:0] MODE_TICK   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_REPORT     = 2'd0;
    localparam logic [1:0] ST_BEGIN_OK   = 2'd1;
    localparam logic [1:0] ST_BEGIN_FAIL = 2'd2;
    localparam logic [1:0] ST_INACTIVE   = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  table_index;
        logic [7:0]  first_entry;
        logic [8:0]  entry_count;
        logic [15:0] duration;
        logic [7:0]  bank;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] series;
        logic [7:0] frame_entry;
        logic       advanced;
        logic       last;
    } t_out_item;

    // bank entry: count saturates just above the series limit
    typedef struct packed {
        logic [7:0]        first;
        logic [BCNT_W-1:0] count;
    } t_bank_ent;

    typedef struct packed {
        logic [7:0] first;
        logic [8:0] count;
    } t_ser_ent;

    typedef struct packed {
        logic       accept;
        logic       prog_clr;
        logic       set_running;
        logic       idx_clr;
        logic       idx_inc;
        logic       next_cap;
        logic       rem_dec;
        logic       rem_load;
        logic       res_new;
        logic [1:0] res_status;
        logic       res_adv;
        logic       flush;
    } t_cmd;

    typedef struct packed {
        logic is_begin;
        logic bank_bad;
        logic running;
        logic walk_done;
        logic ser_empty;
        logic rem_zero;
        logic out_room;
        logic pend_valid;
    } t_sts;

endpackage

`default_nettype wire

### design/msfs_dpath.sv
// datapath: bank, series and frame tables, per-series progress, result staging
// depends on msfs_pkg; driven by msfs_ctrl through t_cmd
`default_nettype none

module msfs_dpath import msfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    t_bank_ent r_bank_mem [BANK_COUNT];
    t_ser_ent  r_ser_mem  [SERIES_DEPTH];
    logic [15:0] r_frm_mem [FRAME_DEPTH];

    t_in_item     r_item;
    logic         r_running;
    logic [BANK_AW-1:0] r_active_bank;

    t_bank_ent    r_bank_q;
    t_ser_ent     r_ser_q;
    logic [15:0]  r_frm_q;

    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_next;
    logic [7:0]       r_prog_frame [SERIES_LIMIT];
    logic [15:0]      r_prog_rem   [SERIES_LIMIT];

    t_out_item r_pend;
    logic      r_pend_valid;
    t_out_item r_out;
    logic      r_out_valid;

    logic [SLOT_W-1:0] slot;
    logic [8:0]        ser_sum;
    logic [SER_AW-1:0] ser_addr;
    logic [8:0]        frm_sum;
    logic [FRM_AW-1:0] frm_addr;
    logic [IDX_W-1:0]  walk;
    logic [8:0]        next_inc;
    logic [7:0]        rep_frame;
    logic [7:0]        rep_entry;
    logic              is_report;
    logic              out_room;
    logic              out_load;
    t_out_item         new_res;
    t_out_item         out_res;

    assign slot     = r_idx[SLOT_W-1:0];
    assign ser_sum  = {1'b0, r_bank_q.first} + 9'(slot);
    assign ser_addr = SER_AW'(ser_sum);
    assign frm_sum  = {1'b0, r_ser_q.first} + {1'b0, r_next};
    assign frm_addr = FRM_AW'(frm_sum);
    assign walk     = (32'(r_bank_q.count) > SERIES_LIMIT) ? IDX_W'(SERIES_LIMIT)
                                                           : IDX_W'(r_bank_q.count);
    assign next_inc = {1'b0, r_prog_frame[slot]} + 9'd1;

    // table writes land at the accepting edge
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (i_in_item.mode == MODE_FRAME &&
                32'(i_in_item.table_index) < FRAME_DEPTH) begin
                r_frm_mem[FRM_AW'(i_in_item.table_index)] <= i_in_item.duration;
            end
            if (i_in_item.mode == MODE_SERIES &&
                32'(i_in_item.table_index) < SERIES_DEPTH) begin
                r_ser_mem[SER_AW'(i_in_item.table_index)] <=
                    '{first: i_in_item.first_entry, count: i_in_item.entry_count};
            end
            if (i_in_item.mode == MODE_BANK &&
                32'(i_in_item.table_index) < BANK_COUNT) begin
                r_bank_mem[BANK_AW'(i_in_item.table_index)] <= '{
                    first: i_in_item.first_entry,
                    count: (32'(i_in_item.entry_count) > SERIES_LIMIT)
                           ? BCNT_W'(SERIES_LIMIT + 1) : BCNT_W'(i_in_item.entry_count)};
            end
        end
    end

    // registered table reads
    always_ff @(posedge i_clk) begin
        r_bank_q <= r_bank_mem[r_active_bank];
        r_ser_q  <= r_ser_mem[ser_addr];
        r_frm_q  <= r_frm_mem[frm_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_active_bank <= '0;
        end else if (i_cmd.accept && i_in_item.mode == MODE_BEGIN) begin
            r_running     <= 1'b0;
            r_active_bank <= BANK_AW'(i_in_item.bank);
        end else if (i_cmd.set_running) begin
            r_running <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // next frame with wrap; a begin always rewinds to frame zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.next_cap) begin
            if (r_item.mode == MODE_BEGIN || next_inc >= r_ser_q.count) begin
                r_next <= '0;
            end else begin
                r_next <= next_inc[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.prog_clr) begin
            for (int k = 0; k < SERIES_LIMIT; k++) begin
                r_prog_frame[k] <= '0;
                r_prog_rem[k]   <= '0;
            end
        end else if (i_cmd.rem_dec) begin
            r_prog_rem[slot] <= r_prog_rem[slot] - 16'd1;
        end else if (i_cmd.rem_load) begin
            r_prog_frame[slot] <= r_next;
            r_prog_rem[slot]   <= r_frm_q;
        end
    end

    // result building
    assign is_report = (i_cmd.res_status == ST_REPORT);
    assign rep_frame = i_cmd.res_adv ? r_next : r_prog_frame[slot];
    assign rep_entry = r_ser_q.first + rep_frame;

    always_comb begin
        new_res.status      = i_cmd.res_status;
        new_res.series      = is_report ? 3'(slot) : 3'd0;
        new_res.frame_entry = is_report ? rep_entry : 8'd0;
        new_res.advanced    = is_report ? i_cmd.res_adv : 1'b0;
        new_res.last        = 1'b0;
        out_res             = r_pend;
        out_res.last        = i_cmd.flush;
    end

    // one result is held back until it is known whether another follows
    assign out_room = !r_out_valid || !i_out_stall;
    assign out_load = (i_cmd.res_new || i_cmd.flush) && r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.res_new) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_new) begin
            r_pend <= new_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_sts.is_begin   = (r_item.mode == MODE_BEGIN);
    assign o_sts.bank_bad   = (32'(r_item.bank) >= BANK_COUNT) ||
                              (32'(r_bank_q.count) > SERIES_LIMIT);
    assign o_sts.running    = r_running;
    assign o_sts.walk_done  = (r_idx >= walk);
    assign o_sts.ser_empty  = (r_ser_q.count == 9'd0);
    assign o_sts.rem_zero   = (r_prog_rem[slot] == 16'd0);
    assign o_sts.out_room   = out_room;
    assign o_sts.pend_valid = r_pend_valid;

endmodule

`default_nettype wire

### design/msfs_ctrl.sv
// controller: sequences begin and tick items one series at a time
// depends on msfs_pkg; commands msfs_dpath through t_cmd, reads t_sts
`default_nettype none

module msfs_ctrl import msfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_in_mode,
    output logic       o_in_stall,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_BANK_RD  = 8'b0000_0010,
        S_BANK_CHK = 8'b0000_0100,
        S_SER_RD   = 8'b0000_1000,
        S_SER_CHK  = 8'b0001_0000,
        S_FRM_RD   = 8'b0010_0000,
        S_FRM_USE  = 8'b0100_0000,
        S_FLUSH    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   can_emit;

    // a new result pushes the held one out, so the output register needs room
    assign can_emit = !i_sts.pend_valid || i_sts.out_room;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_mode == MODE_BEGIN || i_in_mode == MODE_TICK) begin
                        n_state = S_BANK_RD;
                    end
                end
            end
            S_BANK_RD: begin
                n_state = S_BANK_CHK;
            end
            S_BANK_CHK: begin
                o_cmd.idx_clr = 1'b1;
                if (i_sts.is_begin) begin
                    if (i_sts.bank_bad) begin
                        o_cmd.res_new    = 1'b1;
                        o_cmd.res_status = ST_BEGIN_FAIL;
                        n_state          = S_FLUSH;
                    end else begin
                        o_cmd.prog_clr = 1'b1;
                        n_state        = S_SER_RD;
                    end
                end else if (!i_sts.running) begin
                    o_cmd.res_new    = 1'b1;
                    o_cmd.res_status = ST_INACTIVE;
                    n_state          = S_FLUSH;
                end else begin
                    n_state = S_SER_RD;
                end
            end
            S_SER_RD: begin
                if (i_sts.walk_done) begin
                    if (i_sts.is_begin) begin
                        o_cmd.res_new     = 1'b1;
                        o_cmd.res_status  = ST_BEGIN_OK;
                        o_cmd.set_running = 1'b1;
                    end
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_SER_CHK;
                end
            end
            S_SER_CHK: begin
                if (i_sts.ser_empty) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SER_RD;
                end else if (i_sts.is_begin || i_sts.rem_zero) begin
                    o_cmd.next_cap = 1'b1;
                    n_state        = S_FRM_RD;
                end else if (can_emit) begin
                    o_cmd.rem_dec    = 1'b1;
                    o_cmd.res_new    = 1'b1;
                    o_cmd.res_status = ST_REPORT;
                    o_cmd.idx_inc    = 1'b1;
                    n_state          = S_SER_RD;
                end
            end
            S_FRM_RD: begin
                n_state = S_FRM_USE;
            end
            S_FRM_USE: begin
                if (i_sts.is_begin) begin
                    o_cmd.rem_load = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                    n_state        = S_SER_RD;
                end else if (can_emit) begin
                    o_cmd.rem_load   = 1'b1;
                    o_cmd.res_new    = 1'b1;
                    o_cmd.res_status = ST_REPORT;
                    o_cmd.res_adv    = 1'b1;
                    o_cmd.idx_inc    = 1'b1;
                    n_state          = S_SER_RD;
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_room) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

### design/multi_series_frame_sequencer.sv
// Multi series frame sequencer. Table writes (frame, series, bank) and unknown modes are taken in
// idle and give no result. Begin and tick items are handled one at a time: the bank entry is
// read in S_BANK_RD and checked in S_BANK_CHK, then one series after another, S_SER_RD and
// S_SER_CHK for a series whose time is still counting, and S_FRM_RD and S_FRM_USE added for one
// that loads a frame duration (the single read port of the series table and then of the frame
// table sets this); the item closes with an S_SER_RD that finds the walk done and an S_FLUSH that
// hands over the last beat. A stalled output stretches an item. The next item is taken as soon
// as the final beat of the previous one sits in the output register.
// depends on msfs_pkg, msfs_ctrl, msfs_dpath and the assertion macro header
`default_nettype none
`include "multi_series_frame_sequencer_defines.svh"

module multi_series_frame_sequencer import msfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cmd cmd;
    t_sts sts;

    msfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_item.mode),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    msfs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // a held beat only moves out when the output register can take it
    `MSFS_ASSERT_SAME(a_push_room, (cmd.res_new || cmd.flush) && sts.pend_valid, sts.out_room)
    // every item is fully handed over before the next one is taken
    `MSFS_ASSERT_SAME(a_idle_no_pend, !o_in_stall, !sts.pend_valid)
    // a begin stops the running sequence until it succeeds
    `MSFS_ASSERT_NEXT(a_begin_halts, i_in_valid && !o_in_stall && i_in_item.mode == MODE_BEGIN, !sts.running)

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// testbench for multi_series_frame_sequencer: preloads the tables, runs directed and random beats
// and checks every output beat against a frame sequence predictor held in a scoreboard class
// depends on msfs_pkg and the multi_series_frame_sequencer rtl

module testbench;
    import msfs_pkg::*;

    localparam int IN_W           = $bits(t_in_item);
    localparam int CYCLE_LIMIT    = 500000;
    localparam int ITEMS_PER_PHASE = 14;
    // table entries that random items can reach
    localparam int FRM_USED       = 32;
    localparam int SER_USED       = 16;

    class frame_seq_scoreboard;
        logic [7:0]  bank_first [BANK_COUNT];
        logic [8:0]  bank_cnt   [BANK_COUNT];
        logic [7:0]  ser_first  [SERIES_DEPTH];
        logic [8:0]  ser_cnt    [SERIES_DEPTH];
        logic [15:0] frame_dur  [FRAME_DEPTH];
        int          cur_frame  [SERIES_LIMIT];
        int          hold_left  [SERIES_LIMIT];
        int          act_bank;
        bit          running;
        t_out_item   pending_q[$];
        int          errors;

        function new();
            act_bank = 0;
            running  = 1'b0;
            errors   = 0;
            foreach (cur_frame[i]) begin
                cur_frame[i] = 0;
                hold_left[i] = 0;
            end
        endfunction

        function int frame_slot(int s, int cur);
            return (int'(ser_first[s]) + cur) % FRAME_DEPTH;
        endfunction

        // works out the beats an accepted input causes and queues them
        function void note_item(t_in_item it);
            t_out_item held;
            t_out_item beat;
            bit        have;
            bit        bad;
            bit        adv;
            int        b;
            int        t;
            int        s;
            int        walk;

            have = 1'b0;
            held = '0;
            t    = int'(it.table_index);
            case (it.mode)
                MODE_FRAME: begin
                    if (t < FRAME_DEPTH) frame_dur[t] = it.duration;
                end
                MODE_SERIES: begin
                    if (t < SERIES_DEPTH) begin
                        ser_first[t] = it.first_entry;
                        ser_cnt[t]   = it.entry_count;
                    end
                end
                MODE_BANK: begin
                    if (t < BANK_COUNT) begin
                        bank_first[t] = it.first_entry;
                        bank_cnt[t]   = it.entry_count;
                    end
                end
                MODE_BEGIN: begin
                    running = 1'b0;
                    b = int'(it.bank);
                    bad = (b >= BANK_COUNT);
                    if (!bad) bad = (bank_cnt[b] > SERIES_LIMIT);
                    held.status = bad ? ST_BEGIN_FAIL : ST_BEGIN_OK;
                    have = 1'b1;
                    if (!bad) begin
                        act_bank = b;
                        for (int i = 0; i < SERIES_LIMIT; i++) begin
                            cur_frame[i] = 0;
                            hold_left[i] = 0;
                        end
                        for (int i = 0; i < int'(bank_cnt[b]); i++) begin
                            s = (int'(bank_first[b]) + i) % SERIES_DEPTH;
                            if (ser_cnt[s] != 0) hold_left[i] = int'(frame_dur[frame_slot(s, 0)]);
                        end
                        running = 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (!running) begin
                        held.status = ST_INACTIVE;
                        have = 1'b1;
                    end else begin
                        walk = (bank_cnt[act_bank] > SERIES_LIMIT) ? SERIES_LIMIT
                                                                   : int'(bank_cnt[act_bank]);
                        for (int i = 0; i < walk; i++) begin
                            s = (int'(bank_first[act_bank]) + i) % SERIES_DEPTH;
                            if (ser_cnt[s] == 0) continue;
                            adv = 1'b0;
                            if (hold_left[i] > 0) begin
                                hold_left[i]--;
                            end else begin
                                cur_frame[i] = (cur_frame[i] + 1 >= int'(ser_cnt[s])) ? 0
                                                                                     : cur_frame[i] + 1;
                                hold_left[i] = int'(frame_dur[frame_slot(s, cur_frame[i])]);
                                adv = 1'b1;
                            end
                            beat             = '0;
                            beat.status      = ST_REPORT;
                            beat.series      = 3'(i);
                            beat.frame_entry = 8'(frame_slot(s, cur_frame[i]));
                            beat.advanced    = adv;
                            if (have) pending_q.push_back(held);
                            held = beat;
                            have = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (have) begin
                held.last = 1'b1;
                pending_q.push_back(held);
            end
        endfunction

        function void compare_field(string fname, logic [7:0] want_v, logic [7:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, fname, want_v, got_v);
            end
        endfunction

        function void check_beat(t_out_item got);
            t_out_item want;

            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: beat with nothing expected, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_q.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("series", 8'(want.series), 8'(got.series));
            compare_field("frame_entry", want.frame_entry, got.frame_entry);
            compare_field("advanced", 8'(want.advanced), 8'(got.advanced));
            compare_field("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        items_done = 0;
    int        cycle_count = 0;

    frame_seq_scoreboard sb = new();

    multi_series_frame_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // output side: check the accepted beat, then pick the next stall
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) sb.check_beat(o_out_item);
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    function automatic t_in_item mk(logic [2:0] mode, logic [7:0] tix, logic [7:0] first,
                                    logic [8:0] cnt, logic [15:0] dur, logic [7:0] bank);
        t_in_item it;

        it.mode        = mode;
        it.table_index = tix;
        it.first_entry = first;
        it.entry_count = cnt;
        it.duration    = dur;
        it.bank        = bank;
        return it;
    endfunction

    // random content, mostly well formed: short frames, small counts, in-range indexes
    // series and banks only point at the preloaded part of the tables
    function automatic t_in_item rand_item(logic [2:0] mode);
        t_in_item it;

        it = IN_W'({$urandom, $urandom});
        it.mode = mode;
        it.entry_count = 9'($urandom_range(256));
        case (mode)
            MODE_FRAME: begin
                if ($urandom_range(7) != 0) it.table_index = 8'($urandom_range(FRM_USED - 1));
                if ($urandom_range(9) != 0) it.duration = 16'($urandom_range(3));
            end
            MODE_SERIES: begin
                it.table_index = ($urandom_range(9) == 0) ? 8'($urandom_range(255, SERIES_DEPTH))
                                                          : 8'($urandom_range(SER_USED - 1));
                it.first_entry = 8'($urandom_range(FRM_USED / 2 - 1));
                it.entry_count = ($urandom_range(5) != 0) ? 9'($urandom_range(6))
                                                          : 9'($urandom_range(FRM_USED / 2));
            end
            MODE_BANK: begin
                it.table_index = ($urandom_range(9) == 0) ? 8'($urandom_range(255, BANK_COUNT))
                                                          : 8'($urandom_range(BANK_COUNT - 1));
                it.first_entry = 8'($urandom_range(SER_USED - SERIES_LIMIT));
                if ($urandom_range(5) != 0) it.entry_count = 9'($urandom_range(SERIES_LIMIT));
            end
            MODE_BEGIN: begin
                if ($urandom_range(7) != 0) it.bank = 8'($urandom_range(BANK_COUNT - 1));
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        sb.note_item(it);
        // ignored beats do not count toward the random quota
        if (it.mode <= MODE_TICK &&
            !(it.mode == MODE_SERIES && it.table_index >= SERIES_DEPTH) &&
            !(it.mode == MODE_BANK && it.table_index >= BANK_COUNT))
            items_done++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (sb.pending_q.size() != 0);
    endtask

    initial begin
        t_in_item it;
        int       phase_end;
        int       pick;
        logic [2:0] m;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the table entries that items can reach so nothing unwritten is read
        for (int k = 0; k < FRM_USED; k++) begin
            it = rand_item(MODE_FRAME);
            it.table_index = 8'(k);
            it.duration = 16'($urandom_range(2));
            send_item(it);
        end
        for (int k = 0; k < SER_USED; k++) begin
            it = rand_item(MODE_SERIES);
            it.table_index = 8'(k);
            send_item(it);
        end
        for (int k = 0; k < BANK_COUNT; k++) begin
            it = rand_item(MODE_BANK);
            it.table_index = 8'(k);
            send_item(it);
        end

        // directed: idle tick, bad begins, ignored writes, wraps, rewrites while running
        send_item(mk(MODE_TICK, 8'd0, 8'd0, 9'd0, 16'd0, 8'd0));
        send_item(mk(MODE_BEGIN, 8'd0, 8'd0, 9'd0, 16'd0, 8'd255));
        send_item(mk(MODE_BANK, 8'd255, 8'd0, 9'd1, 16'd0, 8'd0));
        send_item(mk(MODE_SERIES, 8'd64, 8'd0, 9'd1, 16'd0, 8'd0));
        send_item(mk(3'd7, 8'hff, 8'hff, 9'd256, 16'hffff, 8'hff));
        send_item(mk(MODE_FRAME, 8'd254, 8'd0, 9'd0, 16'd0, 8'd0));
        send_item(mk(MODE_FRAME, 8'd255, 8'd0, 9'd0, 16'd0, 8'd0));
        send_item(mk(MODE_FRAME, 8'd0, 8'd0, 9'd0, 16'd0, 8'd0));
        // series crosses the end of the frame table, bank crosses the end of the series table
        send_item(mk(MODE_SERIES, 8'd63, 8'd254, 9'd256, 16'd0, 8'd0));
        send_item(mk(MODE_BANK, 8'd15, 8'd63, 9'd8, 16'd0, 8'd0));
        send_item(mk(MODE_BEGIN, 8'd0, 8'd0, 9'd0, 16'd0, 8'd15));
        repeat (3) send_item(mk(MODE_TICK, 8'd0, 8'd0, 9'd0, 16'd0, 8'd0));
        send_item(mk(MODE_BANK, 8'd15, 8'd63, 9'd256, 16'd0, 8'd0));
        send_item(mk(MODE_TICK, 8'd0, 8'd0, 9'd0, 16'd0, 8'd0));
        send_item(mk(MODE_SERIES, 8'd63, 8'd10, 9'd1, 16'd0, 8'd0));
        send_item(mk(MODE_TICK, 8'd0, 8'd0, 9'd0, 16'd0, 8'd0));
        send_item(mk(MODE_BANK, 8'd4, 8'd0, 9'd9, 16'd0, 8'd0));
        send_item(mk(MODE_BEGIN, 8'd0, 8'd0, 9'd0, 16'd0, 8'd4));
        send_item(mk(MODE_TICK, 8'd0, 8'd0, 9'd0, 16'd0, 8'd0));
        send_item(mk(MODE_BANK, 8'd5, 8'd0, 9'd0, 16'd0, 8'd0));
        send_item(mk(MODE_BEGIN, 8'd0, 8'd0, 9'd0, 16'd0, 8'd5));
        send_item(mk(MODE_TICK, 8'd0, 8'd0, 9'd0, 16'd0, 8'd0));
        send_item(mk(MODE_FRAME, 8'd255, 8'd0, 9'd0, 16'hffff, 8'd0));
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (ph == 2) drain_results();
            phase_end = items_done + ITEMS_PER_PHASE;
            while (items_done < phase_end) begin
                if ($urandom_range(9) < 6) begin
                    // a few table writes, a begin, then a run of ticks
                    repeat ($urandom_range(2)) send_item(rand_item(3'($urandom_range(2))));
                    send_item(rand_item(MODE_BEGIN));
                    repeat ($urandom_range(8, 2)) send_item(rand_item(MODE_TICK));
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 40)      m = MODE_TICK;
                    else if (pick < 55) m = MODE_BEGIN;
                    else if (pick < 70) m = MODE_FRAME;
                    else if (pick < 82) m = MODE_SERIES;
                    else if (pick < 92) m = MODE_BANK;
                    else                m = 3'($urandom_range(7, 5));
                    send_item(rand_item(m));
                end
            end
        end

        drain_results();
        repeat (80) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
